/* rtl/core/matrix_multiply_4x4_core_assert.svh */
// Assertion macros for the matrix multiply core.
`ifndef MATRIX_MULTIPLY_4X4_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MM4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mm4_pkg.sv */
package mm4_pkg;

    localparam int unsigned ELEM_W        = 32;
    localparam int unsigned IDX_W         = 4;
    localparam int unsigned OP_W          = 2;
    localparam int unsigned DIM           = 4;
    localparam int unsigned PROD_W        = 2 * ELEM_W;
    localparam int unsigned SUM_W         = PROD_W + 2;
    localparam int unsigned FRAC_BITS_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_MULTIPLY   = 2'd2
    } t_op;

    // Element write broadcast to every cell
    typedef struct packed {
        logic              we_left;
        logic              we_right;
        logic [IDX_W-1:0]  idx;
        logic [ELEM_W-1:0] value;
    } t_load;

    // Partial sum travelling down the chain
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
        logic [SUM_W-1:0]  sum;
    } t_cell_bus;

endpackage

/* rtl/core/matrix_multiply_4x4_core.sv */
// Channel    Handshake            Ports
// ---------  -------------------  -----------------------------------------------
// command    start && !busy       i_operation, i_element_index, i_element_value
// result     o_valid (1 cycle)    o_product_index, o_product_value, o_last_element
//
// A load transaction does not raise busy; busy stays low and the next command may follow.
// A multiply raises busy until the final result leaves: the sequencer issues the 16 product
// elements, each travels through four multiply-accumulate cells of two
// stages and one saturation stage, so results appear at one per cycle.
// Synchronous active-low reset clears both matrices and all control state.
// Results cannot be stalled; each is shown for exactly one cycle.
module matrix_multiply_4x4_core
    import mm4_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [IDX_W-1:0]         i_element_index,
    input  logic signed [ELEM_W-1:0] i_element_value,
    output logic                     o_valid,
    output logic [IDX_W-1:0]         o_product_index,
    output logic signed [ELEM_W-1:0] o_product_value,
    output logic                     o_last_element
);

    localparam logic [IDX_W-1:0] IDX_LAST = {IDX_W{1'b1}};

    logic              accept;
    t_load             load;
    logic              mul_go;

    // Sequencer: walk the 16 product elements in row-major order
    logic              r_run;
    logic              n_run;
    logic [IDX_W-1:0]  r_cnt;
    logic [IDX_W-1:0]  n_cnt;
    logic              r_busy;
    logic              n_busy;

    t_cell_bus         chain [DIM+1];
    logic [ELEM_W-1:0] sat_value;

    assign accept = start && !r_busy;

    // Decode the command transaction
    always_comb begin
        load.we_left  = 1'b0;
        load.we_right = 1'b0;
        load.idx      = i_element_index;
        load.value    = i_element_value;
        mul_go        = 1'b0;
        if (accept) begin
            case (t_op'(i_operation))
                OP_LOAD_LEFT:  load.we_left  = 1'b1;
                OP_LOAD_RIGHT: load.we_right = 1'b1;
                OP_MULTIPLY:   mul_go        = 1'b1;
                default:       mul_go        = 1'b0;  // drop the unused code
            endcase
        end
    end

    always_comb begin
        n_run  = r_run;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (mul_go) begin
            n_run  = 1'b1;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_run) begin
            // advance; stop issuing after the last element
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == IDX_LAST) begin
                n_run = 1'b0;
            end
        end
        // release busy once the final result leaves
        if (o_valid && o_last_element) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end

    // Head of the chain: a zero partial sum tagged with the element index
    assign chain[0].vld = r_run;
    assign chain[0].idx = r_cnt;
    assign chain[0].sum = '0;

    // Cell k adds left[r][k] * right[k][c]
    for (genvar k = 0; k < DIM; k++) begin : g_cell
        mm4_cell #(
            .CELL_K (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (load),
            .i_bus   (chain[k]),
            .o_bus   (chain[k+1])
        );
    end

    mm4_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bus   (chain[DIM]),
        .o_valid (o_valid),
        .o_idx   (o_product_index),
        .o_value (sat_value),
        .o_last  (o_last_element)
    );

    assign o_product_value = $signed(sat_value);
    assign busy            = r_busy;

`include "matrix_multiply_4x4_core_assert.svh"

    `MM4_ASSERT_NOW(a_result_while_busy, o_valid, r_busy, "result outside a multiply")
    `MM4_ASSERT_NEXT(a_busy_after_mul, mul_go, r_busy, "multiply did not raise busy")
    `MM4_ASSERT_NEXT(a_idle_after_last, o_valid && o_last_element, !r_busy,
        "busy held after the final result")
    `MM4_ASSERT_NEXT(a_index_order, o_valid && !o_last_element,
        o_valid && (o_product_index == IDX_W'($past(o_product_index) + 1'b1)),
        "product elements out of order")

endmodule

/* rtl/core/mm4_cell.sv */
module mm4_cell
    import mm4_pkg::*;
#(
    parameter int unsigned CELL_K = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_load     i_load,
    input  t_cell_bus i_bus,
    output t_cell_bus o_bus
);

    localparam logic [1:0] K = CELL_K[1:0];

    // Column K of the left matrix, row K of the right matrix
    logic [ELEM_W-1:0] r_left  [DIM];
    logic [ELEM_W-1:0] r_right [DIM];

    logic              r_s1_vld;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [SUM_W-1:0]  r_s1_sum;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    t_cell_bus         r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIM; i++) begin
                r_left[i]  <= '0;
                r_right[i] <= '0;
            end
        end else begin
            if (i_load.we_left && (i_load.idx[1:0] == K)) begin
                r_left[i_load.idx[3:2]] <= i_load.value;
            end
            if (i_load.we_right && (i_load.idx[3:2] == K)) begin
                r_right[i_load.idx[1:0]] <= i_load.value;
            end
        end
    end

    always_comb begin
        n_prod = PROD_W'($signed(r_left[i_bus.idx[3:2]]) * $signed(r_right[i_bus.idx[1:0]]));
    end

    // Stage 1: multiply; stage 2: accumulate onto the incoming sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out.vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_bus.vld;
            r_out.vld <= r_s1_vld;
        end
        r_s1_idx  <= i_bus.idx;
        r_s1_sum  <= i_bus.sum;
        r_prod    <= n_prod;
        r_out.idx <= r_s1_idx;
        r_out.sum <= r_s1_sum + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    end

    assign o_bus = r_out;

endmodule

/* rtl/core/mm4_sat.sv */
module mm4_sat
    import mm4_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_bus         i_bus,
    output logic              o_valid,
    output logic [IDX_W-1:0]  o_idx,
    output logic [ELEM_W-1:0] o_value,
    output logic              o_last
);

    localparam logic [ELEM_W-1:0] MAX_POS = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] MIN_NEG = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic [IDX_W-1:0]  IDX_LAST = {IDX_W{1'b1}};

    logic [SUM_W-1:0]  shifted;
    logic              fits;
    logic [ELEM_W-1:0] n_value;
    logic              r_valid;
    logic [IDX_W-1:0]  r_idx;
    logic [ELEM_W-1:0] r_value;
    logic              r_last;

    always_comb begin
        shifted = SUM_W'($signed(i_bus.sum) >>> FRAC_BITS);
        fits    = (&shifted[SUM_W-1:ELEM_W-1]) || !(|shifted[SUM_W-1:ELEM_W-1]);
        if (fits) begin
            n_value = shifted[ELEM_W-1:0];
        end else if (i_bus.sum[SUM_W-1]) begin
            n_value = MIN_NEG;
        end else begin
            n_value = MAX_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.vld;
        end
        r_idx   <= i_bus.idx;
        r_value <= n_value;
        r_last  <= (i_bus.idx == IDX_LAST);
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

/* tb/sv/matrix_multiply_4x4_checker.sv */
module matrix_multiply_4x4_checker
    import mm4_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [IDX_W-1:0]         i_element_index,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  logic                     i_valid,
    input  logic [IDX_W-1:0]         i_product_index,
    input  logic signed [ELEM_W-1:0] i_product_value,
    input  logic                     i_last_element,
    output int                       o_mismatch_count,
    output int                       o_pending_count,
    output int                       o_checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ACC_W = SUM_W;
    localparam logic signed [ACC_W-1:0] SAT_MAX = 66'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -66'sh8000_0000;

    typedef struct packed {
        logic [IDX_W-1:0]         index;
        logic signed [ELEM_W-1:0] value;
        logic                     last;
    } t_product_elem;

    logic signed [ELEM_W-1:0] left_store  [DIM*DIM];
    logic signed [ELEM_W-1:0] right_store [DIM*DIM];
    t_product_elem            expected_products[$];
    int                       mismatches;
    int                       checked;

    // Full-width dot product of one left row and one right column, scaled and clamped.
    function automatic logic signed [ELEM_W-1:0] product_element(int row, int col);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] scaled;
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
            acc = acc + left_store[row*DIM + k] * right_store[k*DIM + col];
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled > SAT_MAX) return 32'h7FFF_FFFF;
        if (scaled < SAT_MIN) return 32'h8000_0000;
        return scaled[ELEM_W-1:0];
    endfunction

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_product_elem want;
        if (!i_rst_n) begin
            for (int i = 0; i < DIM*DIM; i++) begin
                left_store[i]  = '0;
                right_store[i] = '0;
            end
            expected_products.delete();
            mismatches = 0;
            checked    = 0;
        end else begin
            // A result never comes out in the same cycle as its command, so check before predicting.
            if (i_valid) begin
                if (expected_products.size() == 0) begin
                    note_mismatch($sformatf("unexpected element idx=%0d value=%h last=%0d",
                                            i_product_index, i_product_value, i_last_element));
                end else begin
                    want = expected_products.pop_front();
                    checked++;
                    if (i_product_index !== want.index || i_product_value !== want.value ||
                        i_last_element !== want.last) begin
                        note_mismatch($sformatf(
                            "expected idx=%0d value=%h last=%0d, got idx=%0d value=%h last=%0d",
                            want.index, want.value, want.last,
                            i_product_index, i_product_value, i_last_element));
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_operation)
                    OP_LOAD_LEFT: begin
                        left_store[i_element_index] = i_element_value;
                    end
                    OP_LOAD_RIGHT: begin
                        right_store[i_element_index] = i_element_value;
                    end
                    OP_MULTIPLY: begin
                        for (int e = 0; e < DIM*DIM; e++) begin
                            want.index = e[IDX_W-1:0];
                            want.value = product_element(e / DIM, e % DIM);
                            want.last  = (e == DIM*DIM - 1);
                            expected_products.push_back(want);
                        end
                    end
                    default: begin
                        // unused code: no result, stores untouched
                    end
                endcase
            end
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= expected_products.size();
        o_checked_count  <= checked;
    end

endmodule

/* tb/sv/matrix_multiply_4x4_core_test.sv */
module matrix_multiply_4x4_core_test
    import mm4_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC_BITS    = FRAC_BITS_DEF;
    // Unused operation code; the core must ignore it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 330;
    // From here on the sender never idles.
    localparam int QUIET_FROM   = 270;
    // Multiply busy window plus pipeline drain, with margin.
    localparam int TAIL_CYCLES  = 40;
    localparam int DRAIN_LIMIT  = 5000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          operation = OP_LOAD_LEFT;
    logic [IDX_W-1:0]         element_index = '0;
    logic signed [ELEM_W-1:0] element_value = '0;
    logic                     valid;
    logic [IDX_W-1:0]         product_index;
    logic signed [ELEM_W-1:0] product_value;
    logic                     last_element;

    int mismatch_count;
    int pending_count;
    int checked_count;

    int  loads_sent     = 0;
    int  multiplies_sent = 0;
    int  ignored_sent   = 0;
    bit  gaps_enabled   = 1'b1;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    matrix_multiply_4x4_core #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (operation),
        .i_element_index (element_index),
        .i_element_value (element_value),
        .o_valid         (valid),
        .o_product_index (product_index),
        .o_product_value (product_value),
        .o_last_element  (last_element)
    );

    matrix_multiply_4x4_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_operation      (operation),
        .i_element_index  (element_index),
        .i_element_value  (element_value),
        .i_valid          (valid),
        .i_product_index  (product_index),
        .i_product_value  (product_value),
        .i_last_element   (last_element),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_checked_count  (checked_count)
    );

    // Present one command and hold it until the core takes it (start high, busy low
    // at the edge). Optionally drop start for a random burst afterwards.
    task automatic issue_command(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                 logic [ELEM_W-1:0] val);
        start         <= 1'b1;
        operation     <= op;
        element_index <= idx;
        element_value <= val;
        do @(posedge clk); while (busy);
        case (op)
            OP_LOAD_LEFT, OP_LOAD_RIGHT: loads_sent++;
            OP_MULTIPLY:                 multiplies_sent++;
            default:                     ignored_sent++;
        endcase
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Hold off the sender until every predicted product element has come out.
    // The checker's count is registered behind each transaction, so step first.
    task automatic wait_for_products();
        start <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // Element values: mostly small and mid-range Q16.16 numbers, some raw
    // 32-bit patterns and the saturation corners.
    function automatic logic [ELEM_W-1:0] random_element();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                v = int'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
                return v;
            end
            4, 5: begin
                v = int'($urandom_range(0, 32'h03FF_FFFF)) - 32'h0200_0000;
                return v;
            end
            6, 7: return $urandom;
            8: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h0000_0001;
                    4:       return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            default: return '0;
        endcase
    endfunction

    initial begin
        int random_items;
        int shape;
        int count;
        int drain_cycles;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: product of the cleared stores is all zeros.
        issue_command(OP_MULTIPLY, 4'd0, 32'h0000_0000);

        // Positive overflow: element 0 sums two max*max terms.
        issue_command(OP_LOAD_LEFT,  4'd0, 32'h7FFF_FFFF);
        issue_command(OP_LOAD_LEFT,  4'd1, 32'h7FFF_FFFF);
        issue_command(OP_LOAD_RIGHT, 4'd0, 32'h7FFF_FFFF);
        issue_command(OP_LOAD_RIGHT, 4'd4, 32'h7FFF_FFFF);
        wait_for_products();
        // Index and value of a multiply must be ignored.
        issue_command(OP_MULTIPLY, 4'd15, 32'hFFFF_FFFF);

        // Negative overflow: max * min on both terms.
        issue_command(OP_LOAD_RIGHT, 4'd0, 32'h8000_0000);
        issue_command(OP_LOAD_RIGHT, 4'd4, 32'h8000_0000);
        // Unused code must not touch the stores.
        issue_command(OP_UNUSED, 4'd0, 32'h1234_5678);
        issue_command(OP_MULTIPLY, 4'd0, 32'h0000_0000);

        // Shift floors toward minus infinity: -1 raw * 1 raw gives -1, not 0.
        issue_command(OP_LOAD_LEFT,  4'd15, 32'hFFFF_FFFF);
        issue_command(OP_LOAD_RIGHT, 4'd15, 32'h0000_0001);
        // 1.0 * -0.5 in Q16.16.
        issue_command(OP_LOAD_LEFT,  4'd5, 32'h0001_0000);
        issue_command(OP_LOAD_RIGHT, 4'd6, 32'hFFFF_8000);
        // min * min overflows positive.
        issue_command(OP_LOAD_LEFT,  4'd6, 32'h8000_0000);
        issue_command(OP_LOAD_RIGHT, 4'd9, 32'h8000_0000);
        issue_command(OP_UNUSED, 4'd5, 32'h7FFF_FFFF);
        issue_command(OP_MULTIPLY, 4'd7, 32'h8000_0000);

        // Land exactly on both saturation limits without clamping.
        issue_command(OP_LOAD_LEFT,  4'd10, 32'h7FFF_FFFF);
        issue_command(OP_LOAD_RIGHT, 4'd10, 32'h0001_0000);
        issue_command(OP_LOAD_LEFT,  4'd11, 32'h8000_0000);
        issue_command(OP_LOAD_RIGHT, 4'd15, 32'h0001_0000);
        issue_command(OP_MULTIPLY, 4'd3, 32'h5555_AAAA);

        // Random part: mostly load batches closed by a multiply, plus noise.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            gaps_enabled = (random_items < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            if (random_items < QUIET_FROM && $urandom_range(0, 11) == 0) wait_for_products();
            shape = $urandom_range(0, 19);
            if (shape < 12) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Refresh both matrices completely.
                    for (int i = 0; i < DIM*DIM; i++) begin
                        issue_command(OP_LOAD_LEFT,  i[IDX_W-1:0], random_element());
                        issue_command(OP_LOAD_RIGHT, i[IDX_W-1:0], random_element());
                    end
                    random_items += 2 * DIM * DIM;
                end else begin
                    count = $urandom_range(1, 8);
                    repeat (count) begin
                        issue_command($urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT,
                                      IDX_W'($urandom_range(0, 15)), random_element());
                    end
                    random_items += count;
                end
                issue_command(OP_MULTIPLY, IDX_W'($urandom_range(0, 15)), $urandom);
                random_items++;
            end else if (shape < 15) begin
                // Back-to-back multiplies on unchanged stores.
                count = $urandom_range(1, 3);
                repeat (count) issue_command(OP_MULTIPLY, IDX_W'($urandom_range(0, 15)), $urandom);
                random_items += count;
            end else if (shape < 17) begin
                // Ignored codes; not counted as items.
                repeat ($urandom_range(1, 3)) begin
                    issue_command(OP_UNUSED, IDX_W'($urandom_range(0, 15)), $urandom);
                end
            end else begin
                // Broken sequence: loads with no multiply after them.
                count = $urandom_range(1, 6);
                repeat (count) begin
                    issue_command($urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT,
                                  IDX_W'($urandom_range(0, 15)), random_element());
                end
                random_items += count;
            end
        end

        start <= 1'b0;
        drain_cycles = 0;
        while (pending_count != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_count != 0) begin
            $display("%0d predicted product elements never came out", pending_count);
        end
        $display("covered %0d loads, %0d multiplies, %0d ignored codes",
                 loads_sent, multiplies_sent, ignored_sent);
        $display("checked %0d product elements, %0d mismatches",
                 checked_count, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial begin
        #400_000;
        $display("timeout: run did not finish");
        $display("status: fail");
        $finish;
    end

endmodule
